### hdl/wmif_pkg.sv
// Package for the windowed majority input filter.
// Holds item struct types, opcodes and reset constants; no dependencies.
package wmif_pkg;

  localparam int unsigned CountW = 16;
  localparam int unsigned TotalW = 32;

  localparam logic              OP_SAMPLE         = 1'b0;
  localparam logic              OP_ACK            = 1'b1;
  localparam logic [CountW-1:0] FILTER_TIME_RESET = 16'd2;

  typedef struct packed {
    logic op;
    logic pin_level;
  } in_item_t;

  typedef struct packed {
    logic              level;
    logic              rise;
    logic              fall;
    logic              event_pending;
    logic [TotalW-1:0] rises_seen;
    logic              window_closed;
    logic              sample_dropped;
  } out_item_t;

endpackage

### hdl/windowed_majority_input_filter_unit.sv
// Windowed majority input filter with edge detect and pending-event handshake.
// Depends on wmif_pkg for item types, opcodes and reset constants.
//
//   channel | ports                         | direction | handshake
//   in      | in_valid in_ready in_item     | input     | valid/ready
//   out     | out_valid out_ready out_item  | output    | valid/ready
//   cfg     | cfg_we cfg_wdata              | input     | write enable, no wait
//
// One item per cycle while out does not stall: the filter state and the result
// register update at the edge that accepts an item, so a result appears in the cycle after.
// in_ready is high whenever the result register is empty or being drained.
// A stall on out holds the result register and blocks in; no item is lost.
// Synchronous active-low reset clears all state but the result data; filter_time returns to 2.
module windowed_majority_input_filter_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  wmif_pkg::in_item_t          in_item,
  output logic                        out_valid,
  input  logic                        out_ready,
  output wmif_pkg::out_item_t         out_item,
  input  logic                        cfg_we,
  input  logic [wmif_pkg::CountW-1:0] cfg_wdata
);

  logic [wmif_pkg::CountW-1:0] filter_time_r;
  logic [wmif_pkg::CountW-1:0] window_count_r, window_count_nxt;
  logic [wmif_pkg::CountW-1:0] high_tally_r, high_tally_nxt;
  logic                        filtered_r, filtered_nxt;
  logic                        previous_r, previous_nxt;
  logic                        rise_r, rise_nxt;
  logic                        fall_r, fall_nxt;
  logic                        event_r, event_nxt;
  logic                        deferred_r, deferred_nxt;
  logic [wmif_pkg::TotalW-1:0] rise_total_r, rise_total_nxt;
  logic                        out_valid_r;
  wmif_pkg::out_item_t         out_item_r, out_item_nxt;

  logic accept;
  logic closed;
  logic dropped;
  logic new_level;
  logic chk_run;
  logic chk_prev;
  logic chk_filt;

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign new_level = (high_tally_r >= (filter_time_r >> 1));

  always_comb begin
    window_count_nxt = window_count_r;
    high_tally_nxt   = high_tally_r;
    filtered_nxt     = filtered_r;
    previous_nxt     = previous_r;
    event_nxt        = event_r;
    deferred_nxt     = deferred_r;
    closed           = 1'b0;
    dropped          = 1'b0;
    chk_run          = 1'b0;
    chk_prev         = previous_r;
    chk_filt         = filtered_r;
    if (in_item.op == wmif_pkg::OP_ACK) begin
      event_nxt = 1'b0;
      if (deferred_r) begin
        deferred_nxt = 1'b0;
        chk_run      = 1'b1;
      end
    end else if (deferred_r) begin
      dropped = 1'b1;
    end else if (window_count_r < filter_time_r) begin
      window_count_nxt = window_count_r + 1'b1;
      if (in_item.pin_level) begin
        high_tally_nxt = high_tally_r + 1'b1;
      end
    end else begin
      closed           = 1'b1;
      window_count_nxt = '0;
      high_tally_nxt   = '0;
      previous_nxt     = filtered_r;
      filtered_nxt     = new_level;
      chk_prev         = filtered_r;
      chk_filt         = new_level;
      if (event_r) begin
        deferred_nxt = 1'b1;
      end else begin
        chk_run = 1'b1;
      end
    end

    rise_nxt       = rise_r;
    fall_nxt       = fall_r;
    rise_total_nxt = rise_total_r;
    if (chk_run) begin
      rise_nxt  = !chk_prev && chk_filt;
      fall_nxt  = chk_prev && !chk_filt;
      event_nxt = chk_prev ^ chk_filt;
      if (!chk_prev && chk_filt) begin
        rise_total_nxt = rise_total_r + 1'b1;
      end
    end

    out_item_nxt.level          = filtered_nxt;
    out_item_nxt.rise           = rise_nxt;
    out_item_nxt.fall           = fall_nxt;
    out_item_nxt.event_pending  = event_nxt;
    out_item_nxt.rises_seen     = rise_total_nxt;
    out_item_nxt.window_closed  = closed;
    out_item_nxt.sample_dropped = dropped;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_time_r  <= wmif_pkg::FILTER_TIME_RESET;
      window_count_r <= '0;
      high_tally_r   <= '0;
      filtered_r     <= 1'b0;
      previous_r     <= 1'b0;
      rise_r         <= 1'b0;
      fall_r         <= 1'b0;
      event_r        <= 1'b0;
      deferred_r     <= 1'b0;
      rise_total_r   <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        filter_time_r <= cfg_wdata;
      end
      if (accept) begin
        window_count_r <= window_count_nxt;
        high_tally_r   <= high_tally_nxt;
        filtered_r     <= filtered_nxt;
        previous_r     <= previous_nxt;
        rise_r         <= rise_nxt;
        fall_r         <= fall_nxt;
        event_r        <= event_nxt;
        deferred_r     <= deferred_nxt;
        rise_total_r   <= rise_total_nxt;
        out_valid_r    <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_item_r <= out_item_nxt;
    end
  end

  a_deferred_needs_event: assert property (@(posedge clk) disable iff (!rst_n)
    deferred_r |-> event_r)
    else $error("stored edge check without pending event");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(rise_r && fall_r))
    else $error("rise and fall flags both set");

  a_drop_when_deferred: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_item.op == wmif_pkg::OP_SAMPLE && deferred_r)
      |=> (out_valid_r && out_item_r.sample_dropped && !out_item_r.window_closed))
    else $error("sample not dropped while edge check stored");

  a_total_stable_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> $stable(rise_total_r))
    else $error("rise total changed without an item");

  a_close_clears_window: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.window_closed) |-> (window_count_r == '0 && high_tally_r == '0))
    else $error("window not cleared after close");

endmodule

### tb/tb_top.sv
// Self-checking testbench for windowed_majority_input_filter_unit.
// Predicts every result from a local copy of the filter state and compares it
// with the block's output stream; depends on wmif_pkg and the unit RTL only.
module tb_top;

  localparam int CycleLimit = 600000;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  wmif_pkg::in_item_t            in_item = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  wmif_pkg::out_item_t           out_item;
  logic                          cfg_we = 1'b0;
  logic [wmif_pkg::CountW-1:0]   cfg_wdata = '0;

  windowed_majority_input_filter_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // predicted filter state
  logic [wmif_pkg::CountW-1:0] pred_filter_time;
  logic [wmif_pkg::CountW-1:0] pred_window_count;
  logic [wmif_pkg::CountW-1:0] pred_high_tally;
  logic                        pred_level;
  logic                        pred_prev_level;
  logic                        pred_rise;
  logic                        pred_fall;
  logic                        pred_event;
  logic                        pred_deferred;
  logic [wmif_pkg::TotalW-1:0] pred_rise_total;

  wmif_pkg::out_item_t filter_outputs_due[$];
  wmif_pkg::out_item_t due_output;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int items_sent = 0;
  int results_checked = 0;
  int decisions_seen = 0;
  int drops_seen = 0;
  int rises_checked = 0;
  int mismatch_count = 0;
  int cycle_count = 0;
  logic true_level = 1'b0;

  int unsigned window_sizes[8] = '{0, 1, 2, 3, 4, 6, 9, 15};

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("tb_top: timeout after %0d cycles, %0d results still due",
               cycle_count, filter_outputs_due.size());
      $display("tb_top: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (filter_outputs_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("tb_top: unexpected result %p", out_item);
      end else begin
        due_output = filter_outputs_due.pop_front();
        results_checked++;
        if (out_item.window_closed) decisions_seen++;
        if (out_item.sample_dropped) drops_seen++;
        if (out_item.rise) rises_checked++;
        if (out_item !== due_output) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"tb_top: mismatch at result %0d: level %b/%b rise %b/%b fall %b/%b ",
                      "pending %b/%b rises %0d/%0d closed %b/%b dropped %b/%b (exp/act)"},
                     results_checked,
                     due_output.level, out_item.level,
                     due_output.rise, out_item.rise,
                     due_output.fall, out_item.fall,
                     due_output.event_pending, out_item.event_pending,
                     due_output.rises_seen, out_item.rises_seen,
                     due_output.window_closed, out_item.window_closed,
                     due_output.sample_dropped, out_item.sample_dropped);
        end
      end
    end
  end

  function automatic void run_edge_check();
    if (pred_prev_level > pred_level) begin
      pred_fall  = 1'b1;
      pred_rise  = 1'b0;
      pred_event = 1'b1;
    end
    if (pred_prev_level < pred_level) begin
      pred_fall       = 1'b0;
      pred_rise       = 1'b1;
      pred_rise_total = pred_rise_total + 1'b1;
      pred_event      = 1'b1;
    end
    if (!pred_event) begin
      pred_fall = 1'b0;
      pred_rise = 1'b0;
    end
  endfunction

  function automatic wmif_pkg::out_item_t predict_filter(wmif_pkg::in_item_t it);
    wmif_pkg::out_item_t res;
    logic                closed;
    logic                dropped;
    closed  = 1'b0;
    dropped = 1'b0;
    if (it.op == wmif_pkg::OP_ACK) begin
      pred_event = 1'b0;
      if (pred_deferred) begin
        pred_deferred = 1'b0;
        run_edge_check();
      end
    end else if (pred_deferred) begin
      dropped = 1'b1;
    end else if (pred_window_count < pred_filter_time) begin
      pred_window_count = pred_window_count + 1'b1;
      if (it.pin_level) pred_high_tally = pred_high_tally + 1'b1;
    end else begin
      closed            = 1'b1;
      pred_window_count = '0;
      pred_prev_level   = pred_level;
      pred_level        = (pred_high_tally < (pred_filter_time >> 1)) ? 1'b0 : 1'b1;
      pred_high_tally   = '0;
      if (pred_event) pred_deferred = 1'b1;
      else run_edge_check();
    end
    res.level          = pred_level;
    res.rise           = pred_rise;
    res.fall           = pred_fall;
    res.event_pending  = pred_event;
    res.rises_seen     = pred_rise_total;
    res.window_closed  = closed;
    res.sample_dropped = dropped;
    return res;
  endfunction

  task automatic drive_item(input logic op, input logic pin);
    int                 gaps;
    wmif_pkg::in_item_t it;
    gaps = 0;
    while (gaps < 40 && $urandom_range(99) < send_idle_pct) gaps++;
    it.op        = op;
    it.pin_level = pin;
    if (gaps > 0) begin
      in_valid <= 1'b0;
      repeat (gaps) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    filter_outputs_due.push_back(predict_filter(it));
    items_sent++;
  endtask

  task automatic drain_outputs();
    in_valid <= 1'b0;
    while (filter_outputs_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_filter_time(input logic [wmif_pkg::CountW-1:0] value);
    drain_outputs();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    pred_filter_time = value;
  endtask

  task automatic test_default_window_edges();
    drive_item(wmif_pkg::OP_SAMPLE, 1'b1);
    drive_item(wmif_pkg::OP_SAMPLE, 1'b1);
    drive_item(wmif_pkg::OP_SAMPLE, 1'b0);
    drive_item(wmif_pkg::OP_ACK, 1'b0);
    drive_item(wmif_pkg::OP_SAMPLE, 1'b0);
    drive_item(wmif_pkg::OP_SAMPLE, 1'b0);
    drive_item(wmif_pkg::OP_SAMPLE, 1'b1);
    drive_item(wmif_pkg::OP_SAMPLE, 1'b1);
    drive_item(wmif_pkg::OP_SAMPLE, 1'b1);
    drive_item(wmif_pkg::OP_SAMPLE, 1'b0);
    drive_item(wmif_pkg::OP_SAMPLE, 1'b0);
    drive_item(wmif_pkg::OP_SAMPLE, 1'b1);
    drive_item(wmif_pkg::OP_ACK, 1'b1);
    drive_item(wmif_pkg::OP_ACK, 1'b0);
    drive_item(wmif_pkg::OP_ACK, 1'b1);
  endtask

  task automatic test_zero_window();
    write_filter_time(16'd0);
    drive_item(wmif_pkg::OP_SAMPLE, 1'b0);
    drive_item(wmif_pkg::OP_SAMPLE, 1'b1);
    drive_item(wmif_pkg::OP_ACK, 1'b0);
    drive_item(wmif_pkg::OP_SAMPLE, 1'b0);
    drive_item(wmif_pkg::OP_ACK, 1'b1);
  endtask

  task automatic test_write_during_window();
    write_filter_time(16'hFFFF);
    repeat (3) begin
      drive_item(wmif_pkg::OP_SAMPLE, 1'b1);
      drive_item(wmif_pkg::OP_SAMPLE, 1'b0);
    end
    write_filter_time(16'd3);
    drive_item(wmif_pkg::OP_SAMPLE, 1'b0);
    drive_item(wmif_pkg::OP_ACK, 1'b0);
  endtask

  task automatic test_random_traffic(input int send_pct, input int stall_pct,
                                     input int first_size);
    logic pin;
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    for (int k = 0; k < 4; k++) begin
      write_filter_time(wmif_pkg::CountW'(window_sizes[(first_size + k) % 8]));
      repeat (118) begin
        if ($urandom_range(99) < 12) begin
          drive_item(wmif_pkg::OP_ACK, 1'($urandom_range(1)));
        end else begin
          if ($urandom_range(99) < 7) true_level = ~true_level;
          pin = true_level ^ ($urandom_range(99) < 15);
          drive_item(wmif_pkg::OP_SAMPLE, pin);
        end
      end
    end
  endtask

  initial begin
    pred_filter_time  = wmif_pkg::FILTER_TIME_RESET;
    pred_window_count = '0;
    pred_high_tally   = '0;
    pred_level        = 1'b0;
    pred_prev_level   = 1'b0;
    pred_rise         = 1'b0;
    pred_fall         = 1'b0;
    pred_event        = 1'b0;
    pred_deferred     = 1'b0;
    pred_rise_total   = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_window_edges();
    test_zero_window();
    test_write_during_window();
    test_random_traffic(0, 0, 0);
    test_random_traffic(83, 0, 4);
    test_random_traffic(0, 83, 2);
    test_random_traffic(18, 18, 6);

    drain_outputs();
    $display("tb_top: %0d items sent, %0d results checked, %0d mismatches",
             items_sent, results_checked, mismatch_count);
    $display("tb_top: %0d window decisions, %0d dropped samples, %0d rise flags seen",
             decisions_seen, drops_seen, rises_checked);
    if (mismatch_count == 0 && filter_outputs_due.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
